// ===== hdl/tcp_pkg.sv =====
package tcp_pkg;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_E_LO   = 8'h65;
  localparam logic [7:0] CH_E_UP   = 8'h45;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  localparam logic [1:0] REG_RIGHT_ALL   = 2'd0;
  localparam logic [1:0] REG_NUM_RIGHT   = 2'd1;
  localparam logic [1:0] REG_PASS_NO_TAB = 2'd2;

  typedef enum logic [1:0] {
    KIND_UPDATE,
    KIND_IGNORED,
    KIND_OVERFLOW
  } close_kind_t;

  typedef struct packed {
    close_kind_t kind;
    logic        eol;
    logic        set_flag;
    logic        fresh;
  } close_ctl_t;

  typedef struct packed {
    logic [7:0]  column_index;
    logic [15:0] column_width;
    logic        right_justify;
    logic [8:0]  column_count;
    logic        line_ignored;
    logic        column_overflow;
    logic        end_of_line;
  } result_t;

endpackage

// ===== hdl/tcp_front.sv =====
module tcp_front import tcp_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int WIDTH_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  acc,
  input  logic                                  op,
  input  logic [7:0]                            char_code,
  input  logic                                  num_right,
  input  logic                                  pass_no_tab,
  output logic                                  close_vld,
  output close_ctl_t                            close_ctl,
  output logic [$clog2(MAX_COLUMNS)-1:0]        close_addr,
  output logic [WIDTH_BITS-1:0]                 close_len,
  output logic [$clog2(MAX_COLUMNS+1)-1:0]      close_count
);

  localparam int IDX_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam logic [CNT_W-1:0] MAX_IDX = CNT_W'(MAX_COLUMNS);

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_ZERO,
    PH_HEX,
    PH_BODY
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  dot_r, dot_nxt;
  logic                  exp_r, exp_nxt;
  logic                  pct_r, pct_nxt;
  logic                  fail_r, fail_nxt;
  logic [CNT_W-1:0]      cols_r;
  logic [CNT_W-1:0]      fidx_r;
  logic [WIDTH_BITS-1:0] flen_r;
  logic                  has_tab_r;
  logic                  hdr_done_r;
  logic                  part_ok;
  logic                  body_go;
  logic                  is_tab;
  logic                  in_table;
  logic                  fresh;
  logic                  ignore_line;
  logic [CNT_W-1:0]      cols_upd;

  assign part_ok     = !fail_r && (phase_r == PH_ZERO || phase_r == PH_BODY);
  assign is_tab      = (op == OP_BYTE) && (char_code == CH_TAB);
  assign in_table    = fidx_r < MAX_IDX;
  assign fresh       = fidx_r >= cols_r;
  assign ignore_line = (op == OP_EOL) && pass_no_tab && !has_tab_r;
  assign cols_upd    = (in_table && fresh) ? fidx_r + CNT_W'(1) : cols_r;

  // numeric scan of one byte
  always_comb begin
    phase_nxt = phase_r;
    dot_nxt   = dot_r;
    exp_nxt   = exp_r;
    pct_nxt   = pct_r;
    fail_nxt  = fail_r;
    body_go   = 1'b0;
    if (fail_r) begin
    end else if (pct_r) begin
      fail_nxt = 1'b1;
    end else if ((char_code == CH_E_LO || char_code == CH_E_UP) && !exp_r) begin
      if (!part_ok) begin
        fail_nxt = 1'b1;
      end else begin
        exp_nxt   = 1'b1;
        dot_nxt   = 1'b0;
        pct_nxt   = 1'b0;
        phase_nxt = PH_START;
      end
    end else begin
      case (phase_r)
        PH_START: begin
          if (char_code == CH_PLUS || char_code == CH_MINUS) phase_nxt = PH_SIGNED;
          else if (char_code == CH_ZERO) phase_nxt = PH_ZERO;
          else body_go = 1'b1;
        end
        PH_SIGNED: begin
          if (char_code == CH_ZERO) phase_nxt = PH_ZERO;
          else body_go = 1'b1;
        end
        PH_ZERO: begin
          if (char_code == CH_X_LO || char_code == CH_X_UP) begin
            phase_nxt = PH_HEX;
          end else begin
            phase_nxt = PH_BODY;
            body_go   = 1'b1;
          end
        end
        default: body_go = 1'b1;
      endcase
      if (body_go) begin
        if (char_code inside {[CH_ZERO:CH_NINE]}) begin
          phase_nxt = PH_BODY;
        end else if (char_code == CH_DOT) begin
          if (dot_r) fail_nxt = 1'b1;
          dot_nxt   = 1'b1;
          phase_nxt = PH_BODY;
        end else if (char_code == CH_PCT) begin
          pct_nxt   = 1'b1;
          phase_nxt = PH_BODY;
        end else begin
          fail_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    close_vld         = acc && (is_tab || op == OP_EOL);
    close_ctl.eol     = (op == OP_EOL);
    close_ctl.fresh   = fresh;
    close_ctl.set_flag = num_right && hdr_done_r && !part_ok;
    if (ignore_line) close_ctl.kind = KIND_IGNORED;
    else if (!in_table) close_ctl.kind = KIND_OVERFLOW;
    else close_ctl.kind = KIND_UPDATE;
    close_addr  = fidx_r[IDX_W-1:0];
    close_len   = flen_r;
    close_count = ignore_line ? cols_r : cols_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      dot_r      <= 1'b0;
      exp_r      <= 1'b0;
      pct_r      <= 1'b0;
      fail_r     <= 1'b0;
      cols_r     <= '0;
      fidx_r     <= '0;
      flen_r     <= '0;
      has_tab_r  <= 1'b0;
      hdr_done_r <= 1'b0;
    end else if (acc) begin
      if (op == OP_BYTE && !is_tab) begin
        if (flen_r != '1) flen_r <= flen_r + WIDTH_BITS'(1);
        phase_r <= phase_nxt;
        dot_r   <= dot_nxt;
        exp_r   <= exp_nxt;
        pct_r   <= pct_nxt;
        fail_r  <= fail_nxt;
      end else begin
        flen_r  <= '0;
        phase_r <= PH_START;
        dot_r   <= 1'b0;
        exp_r   <= 1'b0;
        pct_r   <= 1'b0;
        fail_r  <= 1'b0;
        if (!ignore_line) cols_r <= cols_upd;
        if (is_tab) begin
          has_tab_r <= 1'b1;
          if (in_table) fidx_r <= fidx_r + CNT_W'(1);
        end else begin
          has_tab_r <= 1'b0;
          fidx_r    <= '0;
          if (!ignore_line) hdr_done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/tcp_table.sv =====
module tcp_table import tcp_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int WIDTH_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  right_all,
  input  logic                                  num_right,
  input  logic                                  close_vld,
  input  close_ctl_t                            close_ctl,
  input  logic [$clog2(MAX_COLUMNS)-1:0]        close_addr,
  input  logic [WIDTH_BITS-1:0]                 close_len,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]      close_count,
  input  logic                                  out_free,
  output logic                                  s1_ready,
  output logic                                  res_vld,
  output result_t                               res
);

  localparam int IDX_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

  // entry: {nonnumeric flag, max width}
  logic [WIDTH_BITS:0]   mem [MAX_COLUMNS];
  logic [WIDTH_BITS:0]   rd_r;

  logic                  s1_vld_r;
  close_ctl_t            s1_ctl_r;
  logic [IDX_W-1:0]      s1_addr_r;
  logic [WIDTH_BITS-1:0] s1_len_r;
  logic [CNT_W-1:0]      s1_count_r;

  logic                  byp_vld_r;
  logic [IDX_W-1:0]      byp_addr_r;
  logic [WIDTH_BITS:0]   byp_data_r;

  logic [WIDTH_BITS:0]   old_ent;
  logic [WIDTH_BITS-1:0] new_w;
  logic                  new_f;
  logic                  commit;
  logic                  wr_en;
  logic [31:0]           idx32;
  logic [31:0]           w32;
  logic [31:0]           cnt32;

  assign commit   = s1_vld_r && out_free;
  assign wr_en    = commit && (s1_ctl_r.kind == KIND_UPDATE);
  assign s1_ready = !s1_vld_r || out_free;
  assign res_vld  = s1_vld_r;

  always_comb begin
    if (byp_vld_r && byp_addr_r == s1_addr_r) old_ent = byp_data_r;
    else if (s1_ctl_r.fresh) old_ent = '0;
    else old_ent = rd_r;
    new_w = (s1_len_r > old_ent[WIDTH_BITS-1:0]) ? s1_len_r : old_ent[WIDTH_BITS-1:0];
    new_f = old_ent[WIDTH_BITS] || s1_ctl_r.set_flag;
    idx32 = 32'(s1_addr_r);
    w32   = 32'(new_w);
    cnt32 = 32'(s1_count_r);
  end

  always_comb begin
    res                 = '0;
    res.column_count    = cnt32[8:0];
    res.end_of_line     = s1_ctl_r.eol;
    res.line_ignored    = (s1_ctl_r.kind == KIND_IGNORED);
    res.column_overflow = (s1_ctl_r.kind == KIND_OVERFLOW);
    if (s1_ctl_r.kind == KIND_UPDATE) begin
      res.column_index  = idx32[7:0];
      res.column_width  = w32[15:0];
      res.right_justify = right_all || (num_right && !new_f);
    end
  end

  always_ff @(posedge clk) begin
    if (close_vld && close_ctl.kind == KIND_UPDATE) rd_r <= mem[close_addr];
    if (wr_en) mem[s1_addr_r] <= {new_f, new_w};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      byp_vld_r <= 1'b0;
    end else begin
      if (close_vld) s1_vld_r <= 1'b1;
      else if (commit) s1_vld_r <= 1'b0;
      if (wr_en) byp_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (close_vld) begin
      s1_ctl_r   <= close_ctl;
      s1_addr_r  <= close_addr;
      s1_len_r   <= close_len;
      s1_count_r <= close_count;
    end
    if (wr_en) begin
      byp_addr_r <= s1_addr_r;
      byp_data_r <= {new_f, new_w};
    end
  end

endmodule

// ===== hdl/tsv_column_profiler_unit.sv =====
// Column profiler for a tab-separated byte stream. One input transaction is taken per clock
// cycle unless the output stalls: in_tuser = 0 carries a text byte, in_tuser = 1 marks end of
// line. Every tab and every end of line closes a field and gives one output transaction via
// the table and output registers; ordinary bytes give none. The per-column table (max width
// plus sticky non-numeric flag) sits in one memory that is read as a field closes and written
// as it leaves the table stage; a bypass lets closes of the same column on consecutive cycles
// see the newest entry. Entries at or above the number of columns seen read as zero, so no
// clearing pass follows reset. Columns at or beyond MAX_COLUMNS are reported with the overflow
// flag and leave the table alone. Configuration registers (right_all at 0x0, num_right at 0x4,
// pass_no_tab at 0x8, bit 0) must be written only while no transaction is in flight.
module tsv_column_profiler_unit import tcp_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int WIDTH_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] char_code
  input  logic        in_tuser,     // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [7:0] column_index, [23:8] column_width,
                                    // [24] right_justify, [33:25] column_count, zero pad
  output logic [1:0]  out_tuser,    // [0] line_ignored, [1] column_overflow
  output logic        out_tlast,    // end_of_line
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

  logic                  right_all_r;
  logic                  num_right_r;
  logic                  pass_no_tab_r;
  logic                  acc;
  logic                  close_vld;
  close_ctl_t            close_ctl;
  logic [IDX_W-1:0]      close_addr;
  logic [WIDTH_BITS-1:0] close_len;
  logic [CNT_W-1:0]      close_count;
  logic                  out_free;
  logic                  s1_ready;
  logic                  res_vld;
  result_t               res;
  logic                  out_vld_r;
  result_t               out_res_r;
  logic                  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[3:2])
      REG_RIGHT_ALL:   cfg_prdata[0] = right_all_r;
      REG_NUM_RIGHT:   cfg_prdata[0] = num_right_r;
      REG_PASS_NO_TAB: cfg_prdata[0] = pass_no_tab_r;
      default:         cfg_prdata    = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_all_r   <= 1'b0;
      num_right_r   <= 1'b0;
      pass_no_tab_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_RIGHT_ALL:   right_all_r   <= cfg_pwdata[0];
        REG_NUM_RIGHT:   num_right_r   <= cfg_pwdata[0];
        REG_PASS_NO_TAB: pass_no_tab_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = s1_ready;
  assign acc       = in_tvalid && in_tready;

  tcp_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .WIDTH_BITS  (WIDTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .op          (in_tuser),
    .char_code   (in_tdata),
    .num_right   (num_right_r),
    .pass_no_tab (pass_no_tab_r),
    .close_vld   (close_vld),
    .close_ctl   (close_ctl),
    .close_addr  (close_addr),
    .close_len   (close_len),
    .close_count (close_count)
  );

  tcp_table #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .WIDTH_BITS  (WIDTH_BITS)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .right_all   (right_all_r),
    .num_right   (num_right_r),
    .close_vld   (close_vld),
    .close_ctl   (close_ctl),
    .close_addr  (close_addr),
    .close_len   (close_len),
    .close_count (close_count),
    .out_free    (out_free),
    .s1_ready    (s1_ready),
    .res_vld     (res_vld),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_vld) out_res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_res_r.column_count, out_res_r.right_justify,
                       out_res_r.column_width, out_res_r.column_index};
  assign out_tuser  = {out_res_r.column_overflow, out_res_r.line_ignored};
  assign out_tlast  = out_res_r.end_of_line;

endmodule
